// ----- hw/rtl/rvd_pkg.sv -----
// Shared types and constants for the rolling volatility and drawdown block.
// Holds the window size, the sequencer state type and the request and response
// structs of the shared divider and square-root units. No dependencies.
package rvd_pkg;

  localparam int unsigned WINDOW = 20;
  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  // A sum of WINDOW signed 32-bit returns.
  localparam int unsigned RSUM_W = 33 + $clog2(WINDOW);

  localparam logic [8:0] DAYS_RESET = 9'd252;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RET,
    S_RET_FIN,
    S_RING_UPD,
    S_OVR_ACC,
    S_WMEAN_FIN,
    S_WSQ_MUL,
    S_WSQ_ACC,
    S_ANN_LO,
    S_ANN_HI,
    S_ANN_SUM,
    S_SQRT_WAIT,
    S_DD,
    S_DD_FIN,
    S_SUM,
    S_MEAN_FIN,
    S_PROD_HI,
    S_PROD_SUM,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

// ----- hw/rtl/rvd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the return window. No dependencies.
module rvd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rvd_mul.sv -----
// Shared 32 x 32 unsigned multiplier with a registered product.
// No dependencies.
module rvd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ----- hw/rtl/rvd_div.sv -----
// Shared 64-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on rvd_pkg for its request and response structs.
module rvd_div (
  input  logic             clk,
  input  logic             rst_n,
  input  rvd_pkg::div_req_t req,
  output rvd_pkg::div_rsp_t rsp
);
  import rvd_pkg::*;

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] den_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] shifted;
  logic        ge;

  always_comb begin
    shifted = {rem_r, quo_r[63]};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? 64'(shifted - {1'b0, den_r}) : shifted[63:0];
    quo_nxt = {quo_r[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        den_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// ----- hw/rtl/rvd_sqrt.sv -----
// Shared floor square root of a 64-bit value, one root bit per cycle.
// Depends on rvd_pkg for its request and response structs.
module rvd_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  rvd_pkg::sqrt_req_t req,
  output rvd_pkg::sqrt_rsp_t rsp
);
  import rvd_pkg::*;

  logic [63:0] rad_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [35:0] r4;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    r4    = {rem_r[33:0], rad_r[63:62]};
    trial = {2'b00, root_r, 2'b01};
    ge    = r4 >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= req.radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[61:0], 2'b00};
        rem_r  <= ge ? (r4 - trial) : r4;
        root_r <= {root_r[30:0], ge};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

// ----- hw/rtl/rolling_volatility_drawdown.sv -----
// Rolling volatility and drawdown of a daily price series: top level with the sequencer.
// Depends on rvd_pkg, rvd_ram, rvd_mul, rvd_div and rvd_sqrt.
//
// One price row is taken per item and one result item is given for it. The block is
// busy from the moment it takes a row until it has placed the result in its output
// register, which can then wait for the consumer while the next row is taken. The time a
// row takes is set by the shared 64-bit divider, which is used up to six times for one row
// (return, window mean, window variance, drawdown and, on the last row, the overall mean
// and variance), by the shared square-root unit, and by the pass over the 20-entry return
// window through the shared multiplier. Returns and volatilities are Q8.24, drawdowns
// Q1.24. The days-per-year register may be written while the block is idle; it scales
// the variance before the square root. After the result of a row marked last, the whole
// series state returns to its reset value and a new series begins.
module rolling_volatility_drawdown (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_days_per_year,
  // Input rows
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_date_code,
  input  logic [31:0]        in_open_price,
  input  logic [31:0]        in_close_price,
  input  logic               in_open_present,
  input  logic               in_close_present,
  input  logic               in_last_row,
  // Results
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_return_valid,
  output logic signed [31:0] out_daily_return,
  output logic               out_window_valid,
  output logic [31:0]        out_window_vol,
  output logic [31:0]        out_row_date,
  output logic [24:0]        out_deepest_drawdown,
  output logic [31:0]        out_bottom_date,
  output logic               out_summary_valid,
  output logic signed [31:0] out_mean_return,
  output logic [31:0]        out_annual_vol
);
  import rvd_pkg::*;

  // Sequencer state and the state it resumes after a division.
  state_t state_r, state_nxt;
  state_t div_ret_r, div_ret_nxt;

  logic [8:0] days_r, days_nxt;

  // The row being worked on.
  logic [31:0] date_r, date_nxt;
  logic [31:0] open_r, open_nxt;
  logic [31:0] close_r, close_nxt;
  logic        open_ok_r, open_ok_nxt;
  logic        close_ok_r, close_ok_nxt;
  logic        last_r, last_nxt;

  // Series state.
  logic [31:0]       prev_close_r, prev_close_nxt;
  logic              prev_ok_r, prev_ok_nxt;
  logic              peak_ok_r, peak_ok_nxt;
  logic [31:0]       peak_r, peak_nxt;
  logic [24:0]       worst_r, worst_nxt;
  logic [31:0]       worst_date_r, worst_date_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [RSUM_W-1:0] ring_sum_r, ring_sum_nxt;
  logic [31:0]       count_r, count_nxt;
  logic [63:0]       sum_r, sum_nxt;
  logic [63:0]       sq_r, sq_nxt;

  // Working values of the current item.
  logic        ret_neg_r, ret_neg_nxt;
  logic        rvalid_r, rvalid_nxt;
  logic [31:0] ret_r, ret_nxt;
  logic        wvalid_r, wvalid_nxt;
  logic [31:0] wvol_r, wvol_nxt;
  logic [31:0] mean_r, mean_nxt;
  logic [31:0] avol_r, avol_nxt;
  logic [32:0] m_r, m_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [PTR_W-1:0] k_r, k_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic        ann_overall_r, ann_overall_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic        o_rvalid_r, o_rvalid_nxt;
  logic [31:0] o_ret_r, o_ret_nxt;
  logic        o_wvalid_r, o_wvalid_nxt;
  logic [31:0] o_wvol_r, o_wvol_nxt;
  logic [31:0] o_date_r, o_date_nxt;
  logic [24:0] o_dd_r, o_dd_nxt;
  logic [31:0] o_trough_r, o_trough_nxt;
  logic        o_svalid_r, o_svalid_nxt;
  logic [31:0] o_mean_r, o_mean_nxt;
  logic [31:0] o_avol_r, o_avol_nxt;

  // Shared units.
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_q;

  // Combinational helpers.
  logic [32:0]       ret_diff;
  logic [31:0]       ret_mag;
  logic [31:0]       ret_abs;
  logic [RSUM_W-1:0] rs_tmp;
  logic [RSUM_W-1:0] rs_abs;
  logic [64:0]       sat_sum;
  logic [33:0]       wdiff;
  logic [31:0]       wmag;
  logic [95:0]       wide;
  logic [63:0]       sum_abs;
  logic [31:0]       new_peak;
  logic [31:0]       mean_q;

  rvd_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  rvd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  rvd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rvd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    div_ret_nxt     = div_ret_r;
    days_nxt        = days_r;
    date_nxt        = date_r;
    open_nxt        = open_r;
    close_nxt       = close_r;
    open_ok_nxt     = open_ok_r;
    close_ok_nxt    = close_ok_r;
    last_nxt        = last_r;
    prev_close_nxt  = prev_close_r;
    prev_ok_nxt     = prev_ok_r;
    peak_ok_nxt     = peak_ok_r;
    peak_nxt        = peak_r;
    worst_nxt       = worst_r;
    worst_date_nxt  = worst_date_r;
    fill_nxt        = fill_r;
    ptr_nxt         = ptr_r;
    ring_sum_nxt    = ring_sum_r;
    count_nxt       = count_r;
    sum_nxt         = sum_r;
    sq_nxt          = sq_r;
    ret_neg_nxt     = ret_neg_r;
    rvalid_nxt      = rvalid_r;
    ret_nxt         = ret_r;
    wvalid_nxt      = wvalid_r;
    wvol_nxt        = wvol_r;
    mean_nxt        = mean_r;
    avol_nxt        = avol_r;
    m_nxt           = m_r;
    acc_nxt         = acc_r;
    k_nxt           = k_r;
    lo_nxt          = lo_r;
    ann_overall_nxt = ann_overall_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    o_rvalid_nxt    = o_rvalid_r;
    o_ret_nxt       = o_ret_r;
    o_wvalid_nxt    = o_wvalid_r;
    o_wvol_nxt      = o_wvol_r;
    o_date_nxt      = o_date_r;
    o_dd_nxt        = o_dd_r;
    o_trough_nxt    = o_trough_r;
    o_svalid_nxt    = o_svalid_r;
    o_mean_nxt      = o_mean_r;
    o_avol_nxt      = o_avol_r;

    div_req  = '0;
    sqrt_req = '0;
    mul_a    = '0;
    mul_b    = '0;
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = ret_r;
    ram_raddr = ptr_r;

    ret_diff = {1'b0, open_r} - {1'b0, prev_close_r};
    ret_mag  = ret_diff[32] ? 32'(~ret_diff[31:0] + 32'd1) : ret_diff[31:0];
    ret_abs  = ret_r[31] ? (~ret_r + 32'd1) : ret_r;
    rs_abs   = ring_sum_r[RSUM_W-1] ? (~ring_sum_r + 1'b1) : ring_sum_r;
    sum_abs  = sum_r[63] ? (~sum_r + 64'd1) : sum_r;
    wdiff    = {{2{ram_q[31]}}, ram_q} - {m_r[32], m_r};
    wmag     = wdiff[33] ? 32'(~wdiff + 34'd1) : wdiff[31:0];
    sat_sum  = {1'b0, acc_r} + {1'b0, mul_p};
    rs_tmp   = ring_sum_r;
    wide     = ({32'd0, mul_p} << 32) + {32'd0, lo_r};
    new_peak = (close_r > peak_r) ? close_r : peak_r;
    mean_q   = div_rsp.quot[31:0];

    if (cfg_valid && cfg_ready) begin
      days_nxt = cfg_days_per_year;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          date_nxt     = in_date_code;
          open_nxt     = in_open_price;
          close_nxt    = in_close_price;
          open_ok_nxt  = in_open_present;
          close_ok_nxt = in_close_present;
          last_nxt     = in_last_row;
          rvalid_nxt   = 1'b0;
          ret_nxt      = '0;
          wvalid_nxt   = 1'b0;
          wvol_nxt     = '0;
          mean_nxt     = '0;
          avol_nxt     = '0;
          state_nxt    = S_RET;
        end
      end

      S_RET: begin
        // A return needs an open price and a nonzero close on the row before.
        if (open_ok_r && prev_ok_r && (prev_close_r != 32'd0)) begin
          ret_neg_nxt      = ret_diff[32];
          div_req.start    = 1'b1;
          div_req.dividend = {8'd0, ret_mag, 24'd0};
          div_req.divisor  = {32'd0, prev_close_r};
          div_ret_nxt      = S_RET_FIN;
          state_nxt        = S_DIV_WAIT;
        end else begin
          state_nxt = S_DD;
        end
      end

      S_RET_FIN: begin
        if (ret_neg_r) begin
          ret_nxt = ~div_rsp.quot[31:0] + 32'd1;
        end else if (|div_rsp.quot[63:31]) begin
          ret_nxt = 32'h7FFF_FFFF;
        end else begin
          ret_nxt = div_rsp.quot[31:0];
        end
        rvalid_nxt = 1'b1;
        // Fetch the entry about to be replaced.
        ram_raddr  = ptr_r;
        state_nxt  = S_RING_UPD;
      end

      S_RING_UPD: begin
        if (fill_r == FILL_W'(WINDOW)) begin
          rs_tmp = rs_tmp - {{(RSUM_W-32){ram_q[31]}}, ram_q};
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
        ring_sum_nxt = rs_tmp + {{(RSUM_W-32){ret_r[31]}}, ret_r};
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ret_r;
        ptr_nxt   = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
        mul_a     = ret_abs;
        mul_b     = ret_abs;
        state_nxt = S_OVR_ACC;
      end

      S_OVR_ACC: begin
        // Overall statistics stop growing once the count is saturated.
        if (!(&count_r)) begin
          count_nxt = count_r + 32'd1;
          sum_nxt   = sum_r + {{32{ret_r[31]}}, ret_r};
          sat_sum   = {1'b0, sq_r} + {1'b0, mul_p};
          sq_nxt    = sat_sum[64] ? '1 : sat_sum[63:0];
        end
        if (fill_r == FILL_W'(WINDOW)) begin
          wvalid_nxt       = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = 64'(rs_abs);
          div_req.divisor  = 64'(WINDOW);
          div_ret_nxt      = S_WMEAN_FIN;
          state_nxt        = S_DIV_WAIT;
        end else begin
          state_nxt = S_DD;
        end
      end

      S_WMEAN_FIN: begin
        m_nxt     = ring_sum_r[RSUM_W-1] ? 33'(~div_rsp.quot[32:0] + 33'd1)
                                         : div_rsp.quot[32:0];
        acc_nxt   = '0;
        k_nxt     = '0;
        ram_raddr = '0;
        state_nxt = S_WSQ_MUL;
      end

      S_WSQ_MUL: begin
        mul_a     = wmag;
        mul_b     = wmag;
        state_nxt = S_WSQ_ACC;
      end

      S_WSQ_ACC: begin
        acc_nxt = sat_sum[64] ? '1 : sat_sum[63:0];
        if (k_r == PTR_W'(WINDOW - 1)) begin
          div_req.start    = 1'b1;
          div_req.dividend = sat_sum[64] ? '1 : sat_sum[63:0];
          div_req.divisor  = 64'(WINDOW - 1);
          ann_overall_nxt  = 1'b0;
          div_ret_nxt      = S_ANN_LO;
          state_nxt        = S_DIV_WAIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          ram_raddr = k_r + 1'b1;
          state_nxt = S_WSQ_MUL;
        end
      end

      // Annualising: variance quotient times days per year, in two halves.
      S_ANN_LO: begin
        mul_a     = div_rsp.quot[31:0];
        mul_b     = {23'd0, days_r};
        state_nxt = S_ANN_HI;
      end

      S_ANN_HI: begin
        lo_nxt    = mul_p;
        mul_a     = div_rsp.quot[63:32];
        mul_b     = {23'd0, days_r};
        state_nxt = S_ANN_SUM;
      end

      S_ANN_SUM: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = (|wide[95:64]) ? '1 : wide[63:0];
        state_nxt         = S_SQRT_WAIT;
      end

      S_SQRT_WAIT: begin
        if (sqrt_rsp.done) begin
          if (ann_overall_r) begin
            avol_nxt  = sqrt_rsp.root;
            state_nxt = S_OUT;
          end else begin
            wvol_nxt  = sqrt_rsp.root;
            state_nxt = S_DD;
          end
        end
      end

      S_DD: begin
        if (close_ok_r) begin
          prev_close_nxt = close_r;
        end
        prev_ok_nxt = close_ok_r;
        state_nxt   = S_SUM;
        if (close_ok_r) begin
          if (!peak_ok_r) begin
            // The first close only sets the peak.
            peak_ok_nxt = 1'b1;
            peak_nxt    = close_r;
          end else begin
            peak_nxt = new_peak;
            if (new_peak != 32'd0) begin
              div_req.start    = 1'b1;
              div_req.dividend = {8'd0, 32'(new_peak - close_r), 24'd0};
              div_req.divisor  = {32'd0, new_peak};
              div_ret_nxt      = S_DD_FIN;
              state_nxt        = S_DIV_WAIT;
            end
          end
        end
      end

      S_DD_FIN: begin
        // A tie keeps the older trough date.
        if (div_rsp.quot[24:0] > worst_r) begin
          worst_nxt      = div_rsp.quot[24:0];
          worst_date_nxt = date_r;
        end
        state_nxt = S_SUM;
      end

      S_SUM: begin
        if (last_r && (count_r != 32'd0)) begin
          div_req.start    = 1'b1;
          div_req.dividend = sum_abs;
          div_req.divisor  = {32'd0, count_r};
          div_ret_nxt      = S_MEAN_FIN;
          state_nxt        = S_DIV_WAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_MEAN_FIN: begin
        mean_nxt = sum_r[63] ? (~mean_q + 32'd1) : mean_q;
        if (count_r == 32'd1) begin
          state_nxt = S_OUT;
        end else if (&sq_r) begin
          avol_nxt  = '1;
          state_nxt = S_OUT;
        end else begin
          // |sum| * |mean|, low half first.
          mul_a     = sum_abs[31:0];
          mul_b     = mean_q;
          m_nxt     = {1'b0, mean_q};
          state_nxt = S_PROD_HI;
        end
      end

      S_PROD_HI: begin
        lo_nxt    = mul_p;
        mul_a     = sum_abs[63:32];
        mul_b     = m_r[31:0];
        state_nxt = S_PROD_SUM;
      end

      S_PROD_SUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = (wide <= {32'd0, sq_r}) ? 64'(sq_r - wide[63:0]) : '0;
        div_req.divisor  = {32'd0, 32'(count_r - 32'd1)};
        ann_overall_nxt  = 1'b1;
        div_ret_nxt      = S_ANN_LO;
        state_nxt        = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = div_ret_r;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_rvalid_nxt  = rvalid_r;
          o_ret_nxt     = ret_r;
          o_wvalid_nxt  = wvalid_r;
          o_wvol_nxt    = wvol_r;
          o_date_nxt    = date_r;
          o_dd_nxt      = worst_r;
          o_trough_nxt  = worst_date_r;
          o_svalid_nxt  = last_r;
          o_mean_nxt    = mean_r;
          o_avol_nxt    = avol_r;
          if (last_r) begin
            // End of series: start over.
            prev_close_nxt = '0;
            prev_ok_nxt    = 1'b0;
            peak_ok_nxt    = 1'b0;
            peak_nxt       = '0;
            worst_nxt      = '0;
            worst_date_nxt = '0;
            fill_nxt       = '0;
            ptr_nxt        = '0;
            ring_sum_nxt   = '0;
            count_nxt      = '0;
            sum_nxt        = '0;
            sq_nxt         = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_ret_r    <= S_IDLE;
      days_r       <= DAYS_RESET;
      prev_close_r <= '0;
      prev_ok_r    <= 1'b0;
      peak_ok_r    <= 1'b0;
      peak_r       <= '0;
      worst_r      <= '0;
      worst_date_r <= '0;
      fill_r       <= '0;
      ptr_r        <= '0;
      ring_sum_r   <= '0;
      count_r      <= '0;
      sum_r        <= '0;
      sq_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      div_ret_r    <= div_ret_nxt;
      days_r       <= days_nxt;
      prev_close_r <= prev_close_nxt;
      prev_ok_r    <= prev_ok_nxt;
      peak_ok_r    <= peak_ok_nxt;
      peak_r       <= peak_nxt;
      worst_r      <= worst_nxt;
      worst_date_r <= worst_date_nxt;
      fill_r       <= fill_nxt;
      ptr_r        <= ptr_nxt;
      ring_sum_r   <= ring_sum_nxt;
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
      sq_r         <= sq_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    date_r        <= date_nxt;
    open_r        <= open_nxt;
    close_r       <= close_nxt;
    open_ok_r     <= open_ok_nxt;
    close_ok_r    <= close_ok_nxt;
    last_r        <= last_nxt;
    ret_neg_r     <= ret_neg_nxt;
    rvalid_r      <= rvalid_nxt;
    ret_r         <= ret_nxt;
    wvalid_r      <= wvalid_nxt;
    wvol_r        <= wvol_nxt;
    mean_r        <= mean_nxt;
    avol_r        <= avol_nxt;
    m_r           <= m_nxt;
    acc_r         <= acc_nxt;
    k_r           <= k_nxt;
    lo_r          <= lo_nxt;
    ann_overall_r <= ann_overall_nxt;
    o_rvalid_r    <= o_rvalid_nxt;
    o_ret_r       <= o_ret_nxt;
    o_wvalid_r    <= o_wvalid_nxt;
    o_wvol_r      <= o_wvol_nxt;
    o_date_r      <= o_date_nxt;
    o_dd_r        <= o_dd_nxt;
    o_trough_r    <= o_trough_nxt;
    o_svalid_r    <= o_svalid_nxt;
    o_mean_r      <= o_mean_nxt;
    o_avol_r      <= o_avol_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_return_valid     = o_rvalid_r;
  assign out_daily_return     = $signed(o_ret_r);
  assign out_window_valid     = o_wvalid_r;
  assign out_window_vol       = o_wvol_r;
  assign out_row_date         = o_date_r;
  assign out_deepest_drawdown = o_dd_r;
  assign out_bottom_date      = o_trough_r;
  assign out_summary_valid    = o_svalid_r;
  assign out_mean_return      = $signed(o_mean_r);
  assign out_annual_vol       = o_avol_r;

endmodule

// ----- hw/rtl/rvd_checker.sv -----
// Port-level checks for the rolling volatility and drawdown block.
// Bound to the top level rolling_volatility_drawdown; no other dependencies.
module rvd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_return_valid,
  input logic signed [31:0] out_daily_return,
  input logic               out_window_valid,
  input logic [24:0]        out_deepest_drawdown,
  input logic               out_summary_valid,
  input logic signed [31:0] out_mean_return,
  input logic [31:0]        out_annual_vol
);

  // A result item waits until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // The block works on one item at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while the previous one is in work");

  // A window value needs a return on the same row.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_valid |-> out_return_valid)
    else $error("window value given without a return");

  // Summary fields without their valid flag read as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_summary_valid |-> out_mean_return == 0 && out_annual_vol == 0)
    else $error("summary fields nonzero outside the last row");

  // Without its valid flag the return reads as zero, and on such rows the drawdown is at most one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_return_valid |-> out_daily_return == 0 &&
      out_deepest_drawdown <= 25'h100_0000)
    else $error("return or drawdown out of range");

endmodule

bind rolling_volatility_drawdown rvd_checker u_rvd_checker (.*);

// ----- tb/sv/tb_rolling_volatility_drawdown.sv -----
// Testbench for rolling_volatility_drawdown: drives price rows, predicts each result item
// with a local fixed-point model of the returns, window, drawdown and summary statistics.
// Depends on rvd_pkg and the rolling_volatility_drawdown RTL.
`timescale 1ns / 1ps

module tb_rolling_volatility_drawdown;
  import rvd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [8:0] cfg_days_per_year;
  logic in_valid;
  logic in_ready;
  logic [31:0] in_date_code;
  logic [31:0] in_open_price;
  logic [31:0] in_close_price;
  logic in_open_present;
  logic in_close_present;
  logic in_last_row;
  logic out_valid;
  logic out_ready;
  logic out_return_valid;
  logic signed [31:0] out_daily_return;
  logic out_window_valid;
  logic [31:0] out_window_vol;
  logic [31:0] out_row_date;
  logic [24:0] out_deepest_drawdown;
  logic [31:0] out_bottom_date;
  logic out_summary_valid;
  logic signed [31:0] out_mean_return;
  logic [31:0] out_annual_vol;

  // One expected result item.
  typedef struct packed {
    logic        return_valid;
    logic [31:0] daily_return;
    logic        window_valid;
    logic [31:0] window_vol;
    logic [31:0] row_date;
    logic [24:0] deepest_drawdown;
    logic [31:0] bottom_date;
    logic        summary_valid;
    logic [31:0] mean_return;
    logic [31:0] annual_vol;
  } row_result_t;

  row_result_t expected_rows[$];

  // Predictor state for the current price series.
  logic [8:0]         days_per_year_reg;
  logic [31:0]        last_close;
  logic               last_close_seen;
  logic               peak_seen;
  logic [31:0]        peak_close;
  logic [31:0]        worst_dd;
  logic [31:0]        worst_dd_date;
  logic signed [31:0] window_returns[WINDOW];
  int unsigned        window_fill;
  int unsigned        window_ptr;
  longint             window_sum;
  logic [31:0]        series_count;
  longint             series_sum;
  longint unsigned    series_square_sum;

  int unsigned errors;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  bit          hold_receiver;

  rolling_volatility_drawdown u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_days_per_year    (cfg_days_per_year),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_date_code         (in_date_code),
    .in_open_price        (in_open_price),
    .in_close_price       (in_close_price),
    .in_open_present      (in_open_present),
    .in_close_present     (in_close_present),
    .in_last_row          (in_last_row),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_return_valid     (out_return_valid),
    .out_daily_return     (out_daily_return),
    .out_window_valid     (out_window_valid),
    .out_window_vol       (out_window_vol),
    .out_row_date         (out_row_date),
    .out_deepest_drawdown (out_deepest_drawdown),
    .out_bottom_date      (out_bottom_date),
    .out_summary_valid    (out_summary_valid),
    .out_mean_return      (out_mean_return),
    .out_annual_vol       (out_annual_vol)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: ends the run as a failure once the total cycle count reaches LIMIT_CYCLES.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL rolling_volatility_drawdown");
      $finish;
    end
  end

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? 64'd0 - longint'(x) : longint'(x);
  endfunction

  function automatic longint unsigned add_clamped(longint unsigned a, longint unsigned b);
    return (a > U64_MAX - b) ? U64_MAX : a + b;
  endfunction

  // Floor square root of a 64-bit value, bit by bit.
  function automatic logic [31:0] floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  // Divide the squared deviations, scale by the trading days and take the root.
  function automatic logic [31:0] annual_root(longint unsigned sumsq, longint unsigned denom);
    longint unsigned v;
    longint unsigned f;
    v = sumsq / denom;
    f = 64'(days_per_year_reg);
    if (f != 0 && v > U64_MAX / f) v = U64_MAX;
    else v = v * f;
    return floor_root(v);
  endfunction

  task automatic clear_series();
    last_close = 0;
    last_close_seen = 0;
    peak_seen = 0;
    peak_close = 0;
    worst_dd = 0;
    worst_dd_date = 0;
    window_fill = 0;
    window_ptr = 0;
    window_sum = 0;
    series_count = 0;
    series_sum = 0;
    series_square_sum = 0;
  endtask

  // Advance the series by one price row and queue the result item it produces.
  task automatic predict_row(logic [31:0] date, logic [31:0] open_p, logic [31:0] close_p,
                             logic open_ok, logic close_ok, logic last);
    row_result_t res;
    longint q;
    longint m;
    longint unsigned acc;
    longint unsigned d;
    longint unsigned ms;
    longint unsigned mm;
    longint unsigned num;
    logic [31:0] dd;
    res = '0;
    res.row_date = date;
    if (open_ok && last_close_seen && last_close != 0) begin
      q = ((longint'(open_p) - longint'(last_close)) * 64'sd16777216) / longint'(last_close);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      res.daily_return = q[31:0];
      res.return_valid = 1'b1;
    end
    if (close_ok) last_close = close_p;
    last_close_seen = close_ok;

    if (res.return_valid) begin
      if (window_fill >= WINDOW) window_sum -= window_returns[window_ptr];
      window_returns[window_ptr] = res.daily_return;
      window_sum += $signed(res.daily_return);
      window_ptr = (window_ptr + 1) % WINDOW;
      if (window_fill < WINDOW) window_fill++;
      if (window_fill >= WINDOW) begin
        m = window_sum / longint'(WINDOW);
        acc = 0;
        for (int k = 0; k < WINDOW; k++) begin
          d = magnitude(longint'(window_returns[k]) - m);
          acc = add_clamped(acc, d * d);
        end
        res.window_vol = annual_root(acc, WINDOW - 1);
        res.window_valid = 1'b1;
      end
      // The overall statistics stop counting at the top of the 32-bit count.
      if (series_count != 32'hFFFF_FFFF) begin
        d = magnitude($signed(res.daily_return));
        series_count++;
        series_sum += $signed(res.daily_return);
        series_square_sum = add_clamped(series_square_sum, d * d);
      end
    end

    if (close_ok) begin
      if (!peak_seen) begin
        // The first close only sets the peak.
        peak_seen = 1'b1;
        peak_close = close_p;
      end else begin
        dd = 0;
        if (close_p > peak_close) peak_close = close_p;
        if (peak_close != 0)
          dd = 32'(((longint'(peak_close - close_p)) << 24) / longint'(peak_close));
        // A tie keeps the older trough date.
        if (dd > worst_dd) begin
          worst_dd = dd;
          worst_dd_date = date;
        end
      end
    end

    if (last && series_count >= 1) begin
      m = series_sum / longint'(series_count);
      res.mean_return = m[31:0];
      if (series_count >= 2) begin
        if (series_square_sum == U64_MAX) begin
          res.annual_vol = 32'hFFFF_FFFF;
        end else begin
          ms = magnitude(series_sum);
          mm = magnitude(m);
          num = 0;
          if (mm == 0 || ms <= series_square_sum / mm)
            if (ms * mm <= series_square_sum) num = series_square_sum - ms * mm;
          res.annual_vol = annual_root(num, longint'(series_count) - 1);
        end
      end
    end
    res.deepest_drawdown = worst_dd[24:0];
    res.bottom_date = worst_dd_date;
    res.summary_valid = last;
    expected_rows.insert(expected_rows.size(), res);
    if (last) clear_series();
  endtask

  // Checker: compares every accepted result item with the oldest prediction.
  always @(posedge clk) begin
    row_result_t exp_row;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $error("result item with no prediction waiting");
        errors++;
      end else begin
        exp_row = expected_rows.pop_front();
        if (out_return_valid !== exp_row.return_valid) begin
          $error("return_valid exp %0h got %0h", exp_row.return_valid, out_return_valid);
          errors++;
        end
        if (out_daily_return !== exp_row.daily_return) begin
          $error("daily_return exp %0h got %0h", exp_row.daily_return, out_daily_return);
          errors++;
        end
        if (out_window_valid !== exp_row.window_valid) begin
          $error("window_valid exp %0h got %0h", exp_row.window_valid, out_window_valid);
          errors++;
        end
        if (out_window_vol !== exp_row.window_vol) begin
          $error("window_vol exp %0h got %0h", exp_row.window_vol, out_window_vol);
          errors++;
        end
        if (out_row_date !== exp_row.row_date) begin
          $error("row_date exp %0h got %0h", exp_row.row_date, out_row_date);
          errors++;
        end
        if (out_deepest_drawdown !== exp_row.deepest_drawdown) begin
          $error("deepest_drawdown exp %0h got %0h", exp_row.deepest_drawdown,
                 out_deepest_drawdown);
          errors++;
        end
        if (out_bottom_date !== exp_row.bottom_date) begin
          $error("bottom_date exp %0h got %0h", exp_row.bottom_date, out_bottom_date);
          errors++;
        end
        if (out_summary_valid !== exp_row.summary_valid) begin
          $error("summary_valid exp %0h got %0h", exp_row.summary_valid, out_summary_valid);
          errors++;
        end
        if (out_mean_return !== exp_row.mean_return) begin
          $error("mean_return exp %0h got %0h", exp_row.mean_return, out_mean_return);
          errors++;
        end
        if (out_annual_vol !== exp_row.annual_vol) begin
          $error("annual_vol exp %0h got %0h", exp_row.annual_vol, out_annual_vol);
          errors++;
        end
      end
    end
  end

  // Receiver: stalls at the current rate, or holds off entirely during a backpressure test.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_receiver) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Sends one price row: optional idle gap, then valid held until the handshake.
  // Without an idle gap the next row is raised while the block is still busy with the
  // previous one, so no input cycle is lost.
  task automatic send_row(logic [31:0] date, logic [31:0] open_p, logic [31:0] close_p,
                          logic open_ok, logic close_ok, logic last);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_date_code <= date;
    in_open_price <= open_p;
    in_close_price <= close_p;
    in_open_present <= open_ok;
    in_close_present <= close_ok;
    in_last_row <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_row(date, open_p, close_p, open_ok, close_ok, last);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits until every predicted item has arrived, then lets the block go quiet.
  task automatic drain();
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  // Writes the trading-days register while the block is idle.
  task automatic write_days(logic [8:0] days);
    drain();
    cfg_valid <= 1'b1;
    cfg_days_per_year <= days;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    days_per_year_reg = days;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A price near a base with a moderate random move, so returns stay realistic.
  function automatic logic [31:0] price_near(logic [31:0] base);
    longint p;
    p = longint'(base) + longint'($signed($urandom_range(4000))) - 2000;
    if (p < 1) p = 1;
    return p[31:0];
  endfunction

  task automatic test_directed();
    // Extremes of prices and dates, missing fields, a zero close and a zero peak.
    send_row(32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0);           // zero first close
    send_row(32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0); // zero previous close
    send_row(32'h2, 32'hFFFF_FFFF, 32'h1, 1'b1, 1'b1, 1'b0);   // flat return, deep drawdown
    send_row(32'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0); // saturating return
    send_row(32'h4, 32'h0, 32'h1, 1'b1, 1'b1, 1'b0);           // full loss, equal drawdown
    send_row(32'h5, 32'h1, 32'h5, 1'b0, 1'b0, 1'b0);           // nothing present
    send_row(32'h6, 32'h10, 32'h8, 1'b1, 1'b1, 1'b0);          // no return after absent close
    send_row(32'h7, 32'h9, 32'h9, 1'b1, 1'b0, 1'b0);           // open only
    send_row(32'hFFFF_FFFF, 32'h9, 32'h9, 1'b1, 1'b1, 1'b1);   // last row, no return
    send_row(32'hAAAA_5555, 32'h0, 32'h100, 1'b0, 1'b1, 1'b1); // single-row series
    // Series with exactly one return and then two returns.
    send_row(32'h10, 32'h0, 32'd100000, 1'b0, 1'b1, 1'b0);
    send_row(32'h11, 32'd101000, 32'd99000, 1'b1, 1'b1, 1'b1);
    send_row(32'h12, 32'h0, 32'd100000, 1'b0, 1'b1, 1'b0);
    send_row(32'h13, 32'd101000, 32'd99000, 1'b1, 1'b1, 1'b0);
    send_row(32'h14, 32'd97000, 32'd99000, 1'b1, 1'b1, 1'b1);
  endtask

  // One well-formed series of the given length; a few rows drop a field or price.
  task automatic send_series(int unsigned rows);
    logic [31:0] base;
    logic [31:0] date;
    logic open_ok;
    logic close_ok;
    base = $urandom_range(2_000_000, 10_000);
    date = $urandom;
    for (int unsigned i = 0; i < rows; i++) begin
      open_ok = ($urandom_range(99) >= 4);
      close_ok = ($urandom_range(99) >= 4);
      if ($urandom_range(99) < 2) base = $urandom; // wild jump, all bits exercised
      send_row(date + i, price_near(base), price_near(base), open_ok, close_ok,
               i == rows - 1);
      base = price_near(base);
    end
  endtask

  task automatic test_random(int unsigned total);
    int unsigned sent;
    int unsigned rows;
    sent = 0;
    while (sent < total) begin
      rows = ($urandom_range(9) == 0) ? $urandom_range(5, 1) : $urandom_range(60, 22);
      send_series(rows);
      sent += rows;
    end
  endtask

  // The receiver holds off long enough for the output register and the block to fill.
  task automatic test_backpressure();
    fork
      begin
        hold_receiver = 1'b1;
        repeat (3000) @(negedge clk);
        hold_receiver = 1'b0;
      end
      send_series(12);
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_days_per_year = DAYS_RESET;
    in_valid = 1'b0;
    in_date_code = '0;
    in_open_price = '0;
    in_close_price = '0;
    in_open_present = 1'b0;
    in_close_present = 1'b0;
    in_last_row = 1'b0;
    out_ready = 1'b0;
    errors = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_receiver = 1'b0;
    days_per_year_reg = DAYS_RESET;
    clear_series();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(300);
    write_days(9'd1);
    sender_idle_pct = 67;
    test_random(350);
    write_days(9'd366);
    sender_idle_pct = 0;
    receiver_stall_pct = 67;
    test_random(350);
    write_days(9'd511);
    test_directed();
    write_days(9'd0);
    sender_idle_pct = 7;
    receiver_stall_pct = 7;
    test_random(250);
    write_days(9'd365);
    test_backpressure();
    test_random(300);
    write_days(DAYS_RESET);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    test_random(300);
    drain();

    if (errors == 0) begin
      $display("PASS rolling_volatility_drawdown");
    end else begin
      $display("FAIL rolling_volatility_drawdown");
    end
    $finish;
  end

endmodule
